// File: sv/chained_hash_table_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chained hash table engine
// Shared helpers that wrap concurrent assertions on clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_ENGINE_TOP_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_TOP_MACROS_SVH

// Check a property on every edge outside reset.
`define CHTE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define CHTE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: sv/chte_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table engine package
// Sizes, codes, item types and helper functions of the hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

	localparam int POOL_ENTRIES = 64;
	localparam int MAX_BUCKETS  = 256;
	localparam int KEY_BYTES    = 8;

	localparam int IDX_W    = $clog2(POOL_ENTRIES);
	localparam int BUCKET_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int LINK_W   = 7;
	localparam int COUNT_W  = 7;
	localparam int BC_W     = 9;
	localparam int MKL_W    = 4;
	localparam int KEY_W    = 64;
	localparam int LEN_W    = 4;
	localparam int ITEM_W   = 32;
	localparam int HANDLE_W = 6;
	localparam int HASH_W   = 32;
	localparam int DIV_W    = $clog2(HASH_W);

	localparam logic [LINK_W-1:0] NULL_LINK = 7'h7F;
	localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_SELECT = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_KEY_LONG   = 3'd1;
	localparam logic [2:0] ST_POOL_FULL  = 3'd2;
	localparam logic [2:0] ST_BAD_HANDLE = 3'd3;
	localparam logic [2:0] ST_NO_MATCH   = 3'd4;

	localparam logic REG_BUCKET_COUNT   = 1'b0;
	localparam logic REG_MAX_KEY_LENGTH = 1'b1;

	typedef struct packed {
		logic [1:0]          operation;
		logic [KEY_W-1:0]    key;
		logic [LEN_W-1:0]    key_length;
		logic [ITEM_W-1:0]   item;
		logic [HANDLE_W-1:0] entry_handle;
		logic [COUNT_W-1:0]  select_limit;
	} in_item_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [ITEM_W-1:0]   found_item;
		logic [HANDLE_W-1:0] new_handle;
		logic                last;
		logic [COUNT_W-1:0]  item_count;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [LEN_W-1:0]    length;
		logic [ITEM_W-1:0]   item;
		logic [BUCKET_W-1:0] bucket;
	} entry_t;

	function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
		logic [KEY_W-1:0] m;
		m = '0;
		for (int i = 0; i < KEY_W / 8; i++) begin
			if (i < int'(len)) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	function automatic logic is_link(input logic [LINK_W-1:0] v);
		return v < LINK_W'(POOL_ENTRIES);
	endfunction

endpackage

// File: sv/chte_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module chte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/chained_hash_table_engine_top.sv
// ----------------------------------------------------------------------------
// Chained hash table engine
// Separate chaining hash table over a 64 entry pool, FNV-1a 32 bucketing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one operation item
//   (insert, delete, select, clear). in_stall is high whenever the engine is
//   busy; one item is worked on at a time.
//   Output channel out_valid / out_stall / out_data carries result items held
//   in an output register; while the receiver stalls, the register holds and
//   the sequencer waits at its next push.
//   Configuration channel cfg_valid / cfg_ready / cfg_index / cfg_data writes
//   bucket_count (index 0) and max_key_length (index 1); ready while idle.
// Timing:
//   Insert and select hash one key byte a cycle (one 32x32 multiply each),
//   then take the bucket with a bit-serial modulo, then read the chain
//   head/tail memory; insert links the new entry to the old tail in an extra
//   step when the chain already has one. Select reads, then compares, each
//   chain entry visited, holding while an earlier match cannot leave. Every
//   operation ends with a response push that waits on output stalls.
// Reset:
//   Entry valid bits and bucket valid bits clear at once, so the table is
//   empty straight after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "chained_hash_table_engine_top_macros.svh"

module chained_hash_table_engine_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  chte_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output chte_pkg::out_item_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [chte_pkg::BC_W-1:0]  cfg_data
);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_HASH     = 10'b0000000010,
		S_MOD      = 10'b0000000100,
		S_HT_RD    = 10'b0000001000,
		S_HT_USE   = 10'b0000010000,
		S_INS_LINK = 10'b0000100000,
		S_DEL_USE  = 10'b0001000000,
		S_WALK_RD  = 10'b0010000000,
		S_WALK_CHK = 10'b0100000000,
		S_RESP     = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [chte_pkg::BC_W-1:0]  bc_q;
	logic [chte_pkg::MKL_W-1:0] mkl_q;
	logic [chte_pkg::BC_W-1:0]  n_eff;
	logic [chte_pkg::LEN_W-1:0] maxlen_eff;

	// operation registers
	logic [1:0]                    op_q;
	logic [chte_pkg::KEY_W-1:0]    key_q;
	logic [chte_pkg::KEY_W-1:0]    want_q;
	logic [chte_pkg::LEN_W-1:0]    len_q;
	logic [chte_pkg::LEN_W-1:0]    bytes_q;
	logic [chte_pkg::ITEM_W-1:0]   item_q;
	logic [chte_pkg::IDX_W-1:0]    handle_q;
	logic [chte_pkg::COUNT_W-1:0]  limit_q;
	logic [chte_pkg::IDX_W-1:0]    free_q;
	logic [chte_pkg::HASH_W-1:0]   h_q;
	logic [chte_pkg::DIV_W-1:0]    div_cnt_q;
	logic [chte_pkg::BC_W-1:0]     rem_q;
	logic [chte_pkg::BUCKET_W-1:0] bucket_q;
	logic [chte_pkg::LINK_W-1:0]   tail_q;
	logic [chte_pkg::LINK_W-1:0]   cur_q;
	logic [chte_pkg::COUNT_W-1:0]  steps_q;
	logic [chte_pkg::COUNT_W-1:0]  mcount_q;
	logic                          hold_v_q;
	logic [chte_pkg::ITEM_W-1:0]   hold_item_q;
	logic [2:0]                    resp_status_q;
	logic [chte_pkg::HANDLE_W-1:0] resp_handle_q;

	// table state in flops
	logic [chte_pkg::POOL_ENTRIES-1:0] entry_valid_q;
	logic [chte_pkg::MAX_BUCKETS-1:0]  bvalid_q;
	logic [chte_pkg::COUNT_W-1:0]      count_q;

	// output register
	logic                out_valid_q;
	chte_pkg::out_item_t out_q;

	// memory ports
	logic                          data_we, data_re;
	logic [chte_pkg::IDX_W-1:0]    data_waddr, data_raddr;
	chte_pkg::entry_t              data_wdata, data_rdata;
	logic                          next_we, next_re;
	logic [chte_pkg::IDX_W-1:0]    next_waddr;
	logic [chte_pkg::LINK_W-1:0]   next_wdata, next_rdata;
	logic                          prev_we;
	logic [chte_pkg::IDX_W-1:0]    prev_waddr;
	logic [chte_pkg::LINK_W-1:0]   prev_wdata, prev_rdata;
	logic                          head_we, tail_we, ht_re;
	logic [chte_pkg::BUCKET_W-1:0] head_waddr, tail_waddr;
	logic [chte_pkg::LINK_W-1:0]   head_wdata, tail_wdata, head_rdata, tail_rdata;
	logic [chte_pkg::IDX_W-1:0]    link_raddr;

	// working signals
	logic                          accept, out_free, push;
	chte_pkg::out_item_t           push_data;
	logic [chte_pkg::IDX_W-1:0]    first_free;
	logic [chte_pkg::LINK_W-1:0]   head_eff, tail_eff;
	logic [chte_pkg::BC_W:0]       div_t;
	logic [chte_pkg::BC_W-1:0]     rem_next;
	logic                          match, walk_wait, walk_end;
	logic [chte_pkg::HASH_W-1:0]   h_mul;
	logic [chte_pkg::LINK_W-1:0]   del_p, del_n;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// clamp configuration to its working range
	always_comb begin
		if (bc_q == '0) begin
			n_eff = chte_pkg::BC_W'(1);
		end else if (bc_q > chte_pkg::BC_W'(chte_pkg::MAX_BUCKETS)) begin
			n_eff = chte_pkg::BC_W'(chte_pkg::MAX_BUCKETS);
		end else begin
			n_eff = bc_q;
		end
		if (mkl_q > chte_pkg::MKL_W'(chte_pkg::KEY_BYTES)) begin
			maxlen_eff = chte_pkg::LEN_W'(chte_pkg::KEY_BYTES);
		end else begin
			maxlen_eff = mkl_q;
		end
	end

	// lowest free entry of the pool
	always_comb begin
		first_free = '0;
		for (int i = chte_pkg::POOL_ENTRIES - 1; i >= 0; i--) begin
			if (!entry_valid_q[i]) begin
				first_free = chte_pkg::IDX_W'(i);
			end
		end
	end

	// one FNV-1a round and one restoring modulo step
	assign h_mul    = (h_q ^ {24'd0, key_q[7:0]}) * chte_pkg::FNV_PRIME;
	assign div_t    = {rem_q, h_q[chte_pkg::HASH_W-1]};
	assign rem_next = (div_t >= {1'b0, n_eff}) ? chte_pkg::BC_W'(div_t - {1'b0, n_eff})
	                                           : div_t[chte_pkg::BC_W-1:0];

	// an unwritten bucket reads as an empty chain
	assign head_eff = bvalid_q[bucket_q] ? head_rdata : chte_pkg::NULL_LINK;
	assign tail_eff = bvalid_q[bucket_q] ? tail_rdata : chte_pkg::NULL_LINK;

	assign del_p = prev_rdata;
	assign del_n = next_rdata;

	assign match = entry_valid_q[cur_q[chte_pkg::IDX_W-1:0]]
	               && (data_rdata.length == len_q) && (data_rdata.key == want_q);
	assign walk_wait = match && hold_v_q && !out_free;
	assign walk_end  = !chte_pkg::is_link(cur_q)
	                   || (steps_q >= chte_pkg::COUNT_W'(chte_pkg::POOL_ENTRIES))
	                   || (mcount_q >= limit_q);

	// result pushes: held match during the walk, or the final response
	always_comb begin
		push      = 1'b0;
		push_data = '0;
		push_data.item_count = count_q;
		if (state_q == S_RESP && out_free) begin
			push                 = 1'b1;
			push_data.status     = resp_status_q;
			push_data.found_item = (resp_status_q == chte_pkg::ST_OK) ? hold_item_q : '0;
			push_data.new_handle = resp_handle_q;
			push_data.last       = 1'b1;
		end else if (state_q == S_WALK_CHK && match && hold_v_q && out_free) begin
			push                 = 1'b1;
			push_data.status     = chte_pkg::ST_OK;
			push_data.found_item = hold_item_q;
		end
	end

	// memory port control
	always_comb begin
		data_we    = 1'b0;
		data_re    = 1'b0;
		data_waddr = free_q;
		data_raddr = link_raddr;
		data_wdata = '{key: want_q, length: len_q, item: item_q, bucket: bucket_q};
		next_we    = 1'b0;
		next_re    = 1'b0;
		next_waddr = free_q;
		next_wdata = chte_pkg::NULL_LINK;
		prev_we    = 1'b0;
		prev_waddr = free_q;
		prev_wdata = tail_eff;
		head_we    = 1'b0;
		tail_we    = 1'b0;
		head_waddr = bucket_q;
		tail_waddr = bucket_q;
		head_wdata = chte_pkg::LINK_W'(free_q);
		tail_wdata = chte_pkg::LINK_W'(free_q);
		ht_re      = 1'b0;
		link_raddr = cur_q[chte_pkg::IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				link_raddr = in_data.entry_handle[chte_pkg::IDX_W-1:0];
				if (accept && in_data.operation == chte_pkg::OP_DELETE) begin
					data_re = 1'b1;
					next_re = 1'b1;
				end
			end
			S_HT_RD: begin
				ht_re = 1'b1;
			end
			S_HT_USE: begin
				if (op_q == chte_pkg::OP_INSERT) begin
					data_we = 1'b1;
					next_we = 1'b1;
					prev_we = 1'b1;
					tail_we = 1'b1;
					head_we = !chte_pkg::is_link(tail_eff);
				end
			end
			S_INS_LINK: begin
				next_we    = 1'b1;
				next_waddr = tail_q[chte_pkg::IDX_W-1:0];
				next_wdata = chte_pkg::LINK_W'(free_q);
			end
			S_DEL_USE: begin
				head_waddr = data_rdata.bucket;
				tail_waddr = data_rdata.bucket;
				if (chte_pkg::is_link(del_p)) begin
					next_we    = 1'b1;
					next_waddr = del_p[chte_pkg::IDX_W-1:0];
					next_wdata = del_n;
				end else begin
					head_we    = 1'b1;
					head_wdata = del_n;
				end
				if (chte_pkg::is_link(del_n)) begin
					prev_we    = 1'b1;
					prev_waddr = del_n[chte_pkg::IDX_W-1:0];
					prev_wdata = del_p;
				end else begin
					tail_we    = 1'b1;
					tail_wdata = del_p;
				end
			end
			S_WALK_RD: begin
				if (!walk_end) begin
					data_re = 1'b1;
					next_re = 1'b1;
				end
			end
			S_HASH, S_MOD, S_WALK_CHK, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	chte_ram #(.WIDTH($bits(chte_pkg::entry_t)), .DEPTH(chte_pkg::POOL_ENTRIES)) u_data_ram (
		.clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
		.re(data_re), .raddr(data_raddr), .rdata(data_rdata)
	);

	chte_ram #(.WIDTH(chte_pkg::LINK_W), .DEPTH(chte_pkg::POOL_ENTRIES)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.re(next_re), .raddr(link_raddr), .rdata(next_rdata)
	);

	// prev is only read on delete, alongside next
	chte_ram #(.WIDTH(chte_pkg::LINK_W), .DEPTH(chte_pkg::POOL_ENTRIES)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.re(data_re && state_q == S_IDLE), .raddr(link_raddr), .rdata(prev_rdata)
	);

	chte_ram #(.WIDTH(chte_pkg::LINK_W), .DEPTH(chte_pkg::MAX_BUCKETS)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.re(ht_re), .raddr(bucket_q), .rdata(head_rdata)
	);

	chte_ram #(.WIDTH(chte_pkg::LINK_W), .DEPTH(chte_pkg::MAX_BUCKETS)) u_tail_ram (
		.clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
		.re(ht_re), .raddr(bucket_q), .rdata(tail_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			bc_q          <= chte_pkg::BC_W'(256);
			mkl_q         <= chte_pkg::MKL_W'(8);
			entry_valid_q <= '0;
			bvalid_q      <= '0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
			op_q          <= chte_pkg::OP_INSERT;
			key_q         <= '0;
			want_q        <= '0;
			len_q         <= '0;
			bytes_q       <= '0;
			item_q        <= '0;
			handle_q      <= '0;
			limit_q       <= '0;
			free_q        <= '0;
			h_q           <= '0;
			div_cnt_q     <= '0;
			rem_q         <= '0;
			bucket_q      <= '0;
			tail_q        <= chte_pkg::NULL_LINK;
			cur_q         <= chte_pkg::NULL_LINK;
			steps_q       <= '0;
			mcount_q      <= '0;
			hold_v_q      <= 1'b0;
			hold_item_q   <= '0;
			resp_status_q <= chte_pkg::ST_OK;
			resp_handle_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					chte_pkg::REG_BUCKET_COUNT:   bc_q  <= cfg_data;
					chte_pkg::REG_MAX_KEY_LENGTH: mkl_q <= cfg_data[chte_pkg::MKL_W-1:0];
					default: begin
					end
				endcase
			end

			// output register: load on push, drop once taken
			if (push) begin
				out_valid_q <= 1'b1;
				out_q       <= push_data;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q          <= in_data.operation;
						key_q         <= in_data.key;
						want_q        <= in_data.key & chte_pkg::key_mask(in_data.key_length);
						len_q         <= in_data.key_length;
						bytes_q       <= in_data.key_length;
						item_q        <= in_data.item;
						handle_q      <= in_data.entry_handle[chte_pkg::IDX_W-1:0];
						limit_q       <= in_data.select_limit;
						free_q        <= first_free;
						h_q           <= chte_pkg::FNV_BASIS;
						steps_q       <= '0;
						mcount_q      <= '0;
						hold_v_q      <= 1'b0;
						hold_item_q   <= '0;
						resp_status_q <= chte_pkg::ST_OK;
						resp_handle_q <= '0;
						unique case (in_data.operation)
							chte_pkg::OP_INSERT: begin
								if (in_data.key_length > maxlen_eff) begin
									resp_status_q <= chte_pkg::ST_KEY_LONG;
									state_q       <= S_RESP;
								end else if (&entry_valid_q) begin
									resp_status_q <= chte_pkg::ST_POOL_FULL;
									state_q       <= S_RESP;
								end else begin
									state_q <= S_HASH;
								end
							end
							chte_pkg::OP_DELETE: begin
								if (!entry_valid_q[in_data.entry_handle[chte_pkg::IDX_W-1:0]]) begin
									resp_status_q <= chte_pkg::ST_BAD_HANDLE;
									state_q       <= S_RESP;
								end else begin
									state_q <= S_DEL_USE;
								end
							end
							chte_pkg::OP_SELECT: begin
								if (in_data.key_length > chte_pkg::LEN_W'(chte_pkg::KEY_BYTES)
								    || in_data.select_limit == '0) begin
									resp_status_q <= chte_pkg::ST_NO_MATCH;
									state_q       <= S_RESP;
								end else begin
									state_q <= S_HASH;
								end
							end
							chte_pkg::OP_CLEAR: begin
								entry_valid_q <= '0;
								bvalid_q      <= '0;
								count_q       <= '0;
								state_q       <= S_RESP;
							end
							default: begin
							end
						endcase
					end
				end
				S_HASH: begin
					// one key byte a cycle, low byte first
					if (bytes_q == '0) begin
						div_cnt_q <= '0;
						rem_q     <= '0;
						state_q   <= S_MOD;
					end else begin
						h_q     <= h_mul;
						key_q   <= key_q >> 8;
						bytes_q <= bytes_q - chte_pkg::LEN_W'(1);
					end
				end
				S_MOD: begin
					// one quotient bit a cycle, keep the remainder
					rem_q     <= rem_next;
					h_q       <= h_q << 1;
					div_cnt_q <= div_cnt_q + chte_pkg::DIV_W'(1);
					if (&div_cnt_q) begin
						bucket_q <= rem_next[chte_pkg::BUCKET_W-1:0];
						state_q  <= S_HT_RD;
					end
				end
				S_HT_RD: begin
					state_q <= S_HT_USE;
				end
				S_HT_USE: begin
					if (op_q == chte_pkg::OP_INSERT) begin
						bvalid_q[bucket_q] <= 1'b1;
						tail_q             <= tail_eff;
						resp_handle_q      <= chte_pkg::HANDLE_W'(free_q);
						if (chte_pkg::is_link(tail_eff)) begin
							state_q <= S_INS_LINK;
						end else begin
							entry_valid_q[free_q] <= 1'b1;
							count_q               <= count_q + chte_pkg::COUNT_W'(1);
							state_q               <= S_RESP;
						end
					end else begin
						cur_q   <= head_eff;
						state_q <= S_WALK_RD;
					end
				end
				S_INS_LINK: begin
					entry_valid_q[free_q] <= 1'b1;
					count_q               <= count_q + chte_pkg::COUNT_W'(1);
					state_q               <= S_RESP;
				end
				S_DEL_USE: begin
					entry_valid_q[handle_q] <= 1'b0;
					count_q                 <= count_q - chte_pkg::COUNT_W'(1);
					state_q                 <= S_RESP;
				end
				S_WALK_RD: begin
					if (walk_end) begin
						resp_status_q <= hold_v_q ? chte_pkg::ST_OK : chte_pkg::ST_NO_MATCH;
						state_q       <= S_RESP;
					end else begin
						state_q <= S_WALK_CHK;
					end
				end
				S_WALK_CHK: begin
					// hold while an earlier match cannot leave yet
					if (!walk_wait) begin
						if (match) begin
							hold_v_q    <= 1'b1;
							hold_item_q <= data_rdata.item;
							mcount_q    <= mcount_q + chte_pkg::COUNT_W'(1);
						end
						cur_q   <= next_rdata;
						steps_q <= steps_q + chte_pkg::COUNT_W'(1);
						state_q <= S_WALK_RD;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`CHTE_ASSERT(a_count_match, count_q == $countones(entry_valid_q), "stored count out of step with valid bits")
	`CHTE_ASSERT(a_walk_link, (state_q == S_WALK_CHK) |-> chte_pkg::is_link(cur_q), "walk compares a null link")
	`CHTE_ASSERT(a_push_free, push |-> out_free, "result pushed over a waiting result")
	`CHTE_ASSERT(a_limit, (state_q != S_IDLE && op_q == chte_pkg::OP_SELECT) |-> (mcount_q <= limit_q), "select exceeds its limit")
	`CHTE_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "engine not busy after accepting an item")

endmodule
